### rtl/yuv_quad_to_rgb565_macros.svh
// Assertion macros shared by the checker of the quad colour converter.
`ifndef YUV_QUAD_TO_RGB565_MACROS_SVH
`define YUV_QUAD_TO_RGB565_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define YQ2R_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define YQ2R_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/yq2r_pkg.sv
// Shared types and coefficients for the quad YCbCr to RGB565 converter.
package yq2r_pkg;

    // Wide enough for 298*(Y-16) plus the largest chroma term, signed.
    localparam int SUM_W = 20;

    localparam int COEF_Y       = 298;
    localparam int COEF_R_CR    = 409;
    localparam int COEF_G_CB    = -100;
    localparam int COEF_G_CR    = -208;
    localparam int COEF_B_CB    = 516;
    localparam int LUMA_OFFSET  = 16;
    localparam int CHROMA_BIAS  = 128;
    localparam int ROUND_HALF   = 128;

    typedef logic signed [SUM_W-1:0] t_sum;

    // Per-quad chroma contributions, rounding constant already folded in.
    typedef struct packed {
        t_sum r_term;
        t_sum g_term;
        t_sum b_term;
    } t_chroma_terms;

endpackage

### rtl/yq2r_chroma.sv
// Chroma term generator: one set of R/G/B offsets shared by the whole quad.
module yq2r_chroma
    import yq2r_pkg::*;
(
    input  logic [7:0]    i_cb_sample,
    input  logic [7:0]    i_cr_sample,
    output t_chroma_terms o_terms
);

    t_sum d;
    t_sum e;

    assign d = t_sum'(i_cb_sample) - t_sum'(CHROMA_BIAS);
    assign e = t_sum'(i_cr_sample) - t_sum'(CHROMA_BIAS);

    // Constant multipliers only; results fit comfortably in SUM_W bits.
    assign o_terms.r_term = e * t_sum'(COEF_R_CR) + t_sum'(ROUND_HALF);
    assign o_terms.g_term = d * t_sum'(COEF_G_CB) + e * t_sum'(COEF_G_CR)
                          + t_sum'(ROUND_HALF);
    assign o_terms.b_term = d * t_sum'(COEF_B_CB) + t_sum'(ROUND_HALF);

endmodule

### rtl/yq2r_pixel.sv
// Single pixel path: luma scale, add chroma terms, clamp, pack RGB565, byte swap.
module yq2r_pixel
    import yq2r_pkg::*;
(
    input  logic [7:0]    i_luma,
    input  t_chroma_terms i_terms,
    input  logic          i_swap_bytes,
    output logic [15:0]   o_pixel
);

    // Floor shift by 8 then clamp to 0..255.
    function automatic logic [7:0] sat_component(input t_sum sum);
        logic [7:0] res;
        if (sum[SUM_W-1]) begin
            res = 8'd0;
        end else if (|sum[SUM_W-2:16]) begin
            res = 8'hFF;
        end else begin
            res = sum[15:8];
        end
        return res;
    endfunction

    t_sum        c;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [15:0] packed_px;

    assign c = (t_sum'(i_luma) - t_sum'(LUMA_OFFSET)) * t_sum'(COEF_Y);

    assign r = sat_component(c + i_terms.r_term);
    assign g = sat_component(c + i_terms.g_term);
    assign b = sat_component(c + i_terms.b_term);

    assign packed_px = {r[7:3], g[7:2], b[7:3]};
    assign o_pixel   = i_swap_bytes ? {packed_px[7:0], packed_px[15:8]} : packed_px;

endmodule

### rtl/yuv_quad_to_rgb565.sv
// Quad YCbCr 4:2:0 to RGB565 converter, top level.
//
// Input channel (i_valid / o_stall): one beat carries a 2x2 quad - shared Cb
// and Cr, four luma samples and the right-column / lower-row edge flags.
// Output channel (o_valid / i_stall): one beat per quad with four RGB565
// pixels and a presence mask; absent pixels read as zero.
// Config channel (i_cfg_valid / o_cfg_ready): ready is always high; the write
// data sets the byte-swap control. Write it only while the block is idle.
// A beat is taken into the input register, passes the conversion logic and
// is held in the result register that drives the outputs. Throughput: one
// quad per cycle while the receiver does not stall, set by these registers.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more quad; o_stall rises only once both are full.
// Reset (synchronous, active low) empties both registers and clears the
// byte-swap control.
module yuv_quad_to_rgb565
    import yq2r_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beats
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_cb_sample,
    input  logic [7:0]  i_cr_sample,
    input  logic [7:0]  i_luma_top_left,
    input  logic [7:0]  i_luma_top_right,
    input  logic [7:0]  i_luma_bottom_left,
    input  logic [7:0]  i_luma_bottom_right,
    input  logic        i_has_right_column,
    input  logic        i_has_lower_row,
    // result beats
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_pixel_top_left,
    output logic [15:0] o_pixel_top_right,
    output logic [15:0] o_pixel_bottom_left,
    output logic [15:0] o_pixel_bottom_right,
    output logic [3:0]  o_pixel_valid_mask,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_swap_bytes
);

    logic          r_swap_bytes;
    logic          r_in_valid;
    logic [7:0]    r_cb;
    logic [7:0]    r_cr;
    logic [7:0]    r_luma_tl;
    logic [7:0]    r_luma_tr;
    logic [7:0]    r_luma_bl;
    logic [7:0]    r_luma_br;
    logic          r_right;
    logic          r_lower;

    logic          r_out_valid;
    logic [15:0]   r_px_tl;
    logic [15:0]   r_px_tr;
    logic [15:0]   r_px_bl;
    logic [15:0]   r_px_br;
    logic [3:0]    r_mask;

    logic          out_load;
    logic          in_load;
    t_chroma_terms terms;
    logic [15:0]   px_tl;
    logic [15:0]   px_tr;
    logic [15:0]   px_bl;
    logic [15:0]   px_br;
    logic [3:0]    n_mask;

    assign out_load = !r_out_valid || !i_stall;
    assign o_stall  = r_in_valid && !out_load;
    assign in_load  = !o_stall;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap_bytes <= 1'b0;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_swap_bytes <= i_cfg_swap_bytes;
            end
            if (in_load) begin
                r_in_valid <= i_valid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_valid) begin
            r_cb      <= i_cb_sample;
            r_cr      <= i_cr_sample;
            r_luma_tl <= i_luma_top_left;
            r_luma_tr <= i_luma_top_right;
            r_luma_bl <= i_luma_bottom_left;
            r_luma_br <= i_luma_bottom_right;
            r_right   <= i_has_right_column;
            r_lower   <= i_has_lower_row;
        end
    end

    yq2r_chroma u_chroma (
        .i_cb_sample (r_cb),
        .i_cr_sample (r_cr),
        .o_terms     (terms)
    );

    yq2r_pixel u_px_tl (
        .i_luma       (r_luma_tl),
        .i_terms      (terms),
        .i_swap_bytes (r_swap_bytes),
        .o_pixel      (px_tl)
    );

    yq2r_pixel u_px_tr (
        .i_luma       (r_luma_tr),
        .i_terms      (terms),
        .i_swap_bytes (r_swap_bytes),
        .o_pixel      (px_tr)
    );

    yq2r_pixel u_px_bl (
        .i_luma       (r_luma_bl),
        .i_terms      (terms),
        .i_swap_bytes (r_swap_bytes),
        .o_pixel      (px_bl)
    );

    yq2r_pixel u_px_br (
        .i_luma       (r_luma_br),
        .i_terms      (terms),
        .i_swap_bytes (r_swap_bytes),
        .o_pixel      (px_br)
    );

    // top-left always present; bottom-right needs both edges inside
    assign n_mask = {r_right && r_lower, r_lower, r_right, 1'b1};

    always_ff @(posedge i_clk) begin
        if (out_load && r_in_valid) begin
            r_px_tl <= px_tl;
            r_px_tr <= n_mask[1] ? px_tr : 16'd0;
            r_px_bl <= n_mask[2] ? px_bl : 16'd0;
            r_px_br <= n_mask[3] ? px_br : 16'd0;
            r_mask  <= n_mask;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_pixel_top_left     = r_px_tl;
    assign o_pixel_top_right    = r_px_tr;
    assign o_pixel_bottom_left  = r_px_bl;
    assign o_pixel_bottom_right = r_px_br;
    assign o_pixel_valid_mask   = r_mask;

endmodule

### rtl/yq2r_checker.sv
// Port-level checker for the quad converter, bound to the top level.
`include "yuv_quad_to_rgb565_macros.svh"

module yq2r_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_pixel_top_right,
    input logic [15:0] o_pixel_bottom_left,
    input logic [15:0] o_pixel_bottom_right,
    input logic [3:0]  o_pixel_valid_mask
);

    // a stalled result beat must stay on the port
    `YQ2R_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid,
        "result beat dropped while stalled")

    // upstream is only held off when a result is waiting on a stalled receiver
    `YQ2R_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall,
        "input stalled with room in the result register")

    // mask: top-left always there, bottom-right only with both neighbours
    `YQ2R_ASSERT_NOW(a_mask_shape, i_clk, i_rst_n, o_valid,
        o_pixel_valid_mask[0] && (!o_pixel_valid_mask[3] ||
        (o_pixel_valid_mask[1] && o_pixel_valid_mask[2])),
        "inconsistent pixel mask")

    // absent pixels read as zero
    `YQ2R_ASSERT_NOW(a_absent_zero, i_clk, i_rst_n, o_valid,
        (o_pixel_valid_mask[1] || o_pixel_top_right == 16'd0) &&
        (o_pixel_valid_mask[2] || o_pixel_bottom_left == 16'd0) &&
        (o_pixel_valid_mask[3] || o_pixel_bottom_right == 16'd0),
        "absent pixel not zero")

endmodule

bind yuv_quad_to_rgb565 yq2r_checker u_yq2r_checker (.*);

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the quad YCbCr to RGB565 converter.
module tb_top;

    typedef struct packed {
        logic [7:0] cb;
        logic [7:0] cr;
        logic [7:0] y_tl;
        logic [7:0] y_tr;
        logic [7:0] y_bl;
        logic [7:0] y_br;
        logic       right;
        logic       lower;
    } t_quad;

    typedef struct packed {
        logic [15:0] tl;
        logic [15:0] tr;
        logic [15:0] bl;
        logic [15:0] br;
        logic [3:0]  mask;
    } t_rgb_quad;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_cb_sample = '0;
    logic [7:0]  i_cr_sample = '0;
    logic [7:0]  i_luma_top_left = '0;
    logic [7:0]  i_luma_top_right = '0;
    logic [7:0]  i_luma_bottom_left = '0;
    logic [7:0]  i_luma_bottom_right = '0;
    logic        i_has_right_column = 1'b0;
    logic        i_has_lower_row = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_pixel_top_left;
    logic [15:0] o_pixel_top_right;
    logic [15:0] o_pixel_bottom_left;
    logic [15:0] o_pixel_bottom_right;
    logic [3:0]  o_pixel_valid_mask;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_swap_bytes = 1'b0;

    t_quad     pending_quads[$];
    t_rgb_quad rgb_expected[$];
    logic      swap_model = 1'b0;
    logic      idle_on = 1'b1;
    bit        in_beat_taken = 1'b0;
    int        src_gap = 0;
    int        sink_gap = 0;
    int        sink_hold = 0;
    bit        hold_done = 1'b0;
    int        quads_sent = 0;
    int        results_checked = 0;
    int        mismatches = 0;
    int        swap_writes = 0;

    yuv_quad_to_rgb565 dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_cb_sample          (i_cb_sample),
        .i_cr_sample          (i_cr_sample),
        .i_luma_top_left      (i_luma_top_left),
        .i_luma_top_right     (i_luma_top_right),
        .i_luma_bottom_left   (i_luma_bottom_left),
        .i_luma_bottom_right  (i_luma_bottom_right),
        .i_has_right_column   (i_has_right_column),
        .i_has_lower_row      (i_has_lower_row),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_pixel_top_left     (o_pixel_top_left),
        .o_pixel_top_right    (o_pixel_top_right),
        .o_pixel_bottom_left  (o_pixel_bottom_left),
        .o_pixel_bottom_right (o_pixel_bottom_right),
        .o_pixel_valid_mask   (o_pixel_valid_mask),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_swap_bytes     (i_cfg_swap_bytes)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---- colour conversion predictor ----

    function automatic logic [7:0] clamp_component(input int sum);
        int v;
        if (sum < 0)
            return 8'd0;
        v = sum >>> 8;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [15:0] rgb565_of(input logic [7:0] y, input logic [7:0] cb,
                                              input logic [7:0] cr, input logic swap);
        int          c;
        int          d;
        int          e;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [15:0] px;
        c  = 298 * (int'(y) - 16);
        d  = int'(cb) - 128;
        e  = int'(cr) - 128;
        r  = clamp_component(c + 409 * e + 128);
        g  = clamp_component(c - 100 * d - 208 * e + 128);
        b  = clamp_component(c + 516 * d + 128);
        px = {r[7:3], g[7:2], b[7:3]};
        return swap ? {px[7:0], px[15:8]} : px;
    endfunction

    function automatic t_rgb_quad predict_rgb_quad(input t_quad q, input logic swap);
        t_rgb_quad res;
        res      = '0;
        res.tl   = rgb565_of(q.y_tl, q.cb, q.cr, swap);
        res.mask = {q.right & q.lower, q.lower, q.right, 1'b1};
        if (q.right)
            res.tr = rgb565_of(q.y_tr, q.cb, q.cr, swap);
        if (q.lower)
            res.bl = rgb565_of(q.y_bl, q.cb, q.cr, swap);
        if (q.right && q.lower)
            res.br = rgb565_of(q.y_br, q.cb, q.cr, swap);
        return res;
    endfunction

    // ---- input side ----

    always @(posedge i_clk) begin
        in_beat_taken = i_rst_n && i_valid && !o_stall;
        if (in_beat_taken) begin
            rgb_expected.push_back(predict_rgb_quad({i_cb_sample, i_cr_sample,
                i_luma_top_left, i_luma_top_right, i_luma_bottom_left,
                i_luma_bottom_right, i_has_right_column, i_has_lower_row}, swap_model));
            quads_sent++;
        end
    end

    always @(negedge i_clk) begin : quad_driver
        t_quad q;
        if (i_rst_n && (in_beat_taken || !i_valid)) begin
            if (src_gap > 0) begin
                src_gap--;
                i_valid <= 1'b0;
            end else if (in_beat_taken && idle_on && $urandom_range(0, 5) == 0) begin
                src_gap = $urandom_range(0, 18);
                i_valid <= 1'b0;
            end else if (pending_quads.size() > 0) begin
                q = pending_quads.pop_front();
                i_cb_sample         <= q.cb;
                i_cr_sample         <= q.cr;
                i_luma_top_left     <= q.y_tl;
                i_luma_top_right    <= q.y_tr;
                i_luma_bottom_left  <= q.y_bl;
                i_luma_bottom_right <= q.y_br;
                i_has_right_column  <= q.right;
                i_has_lower_row     <= q.lower;
                i_valid             <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ---- output side ----

    task automatic compare_field(input string label, input logic [15:0] exp_v,
                                 input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : rgb_monitor
        t_rgb_quad exp_q;
        if (i_rst_n && o_valid && !i_stall) begin
            if (rgb_expected.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h %h %h %h %h",
                         $time, o_pixel_top_left, o_pixel_top_right, o_pixel_bottom_left,
                         o_pixel_bottom_right, o_pixel_valid_mask);
                mismatches++;
            end else begin
                exp_q = rgb_expected.pop_front();
                compare_field("pixel_top_left", exp_q.tl, o_pixel_top_left);
                compare_field("pixel_top_right", exp_q.tr, o_pixel_top_right);
                compare_field("pixel_bottom_left", exp_q.bl, o_pixel_bottom_left);
                compare_field("pixel_bottom_right", exp_q.br, o_pixel_bottom_right);
                compare_field("pixel_valid_mask", {12'd0, exp_q.mask},
                              {12'd0, o_pixel_valid_mask});
                results_checked++;
            end
        end
    end

    // receiver stall: random bursts plus one long hold to back the pipe up
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold--;
            i_stall <= 1'b1;
        end else if (!hold_done && results_checked >= 250) begin
            hold_done = 1'b1;
            sink_hold = 79;
            i_stall <= 1'b1;
        end else if (sink_gap > 0) begin
            sink_gap--;
            i_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            sink_gap = $urandom_range(0, 18);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ---- stimulus ----

    function automatic t_quad make_quad(input logic [7:0] cb, input logic [7:0] cr,
                                        input logic [7:0] tl, input logic [7:0] tr,
                                        input logic [7:0] bl, input logic [7:0] br,
                                        input logic right, input logic lower);
        return '{cb: cb, cr: cr, y_tl: tl, y_tr: tr, y_bl: bl, y_br: br,
                 right: right, lower: lower};
    endfunction

    // biased towards the ends of the range and the nominal black/white levels
    function automatic logic [7:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(14, 18));
            3:       return 8'($urandom_range(233, 240));
            4:       return 8'($urandom_range(124, 132));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic drain();
        while (pending_quads.size() != 0 || i_valid || rgb_expected.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_swap(input logic value);
        @(negedge i_clk);
        i_cfg_valid      <= 1'b1;
        i_cfg_swap_bytes <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        swap_model = value;
        swap_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int count, input logic swap);
        write_swap(swap);
        repeat (count)
            pending_quads.push_back(make_quad(rand_sample(), rand_sample(), rand_sample(),
                rand_sample(), rand_sample(), rand_sample(),
                $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0));
        drain();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, neutral chroma, every edge-flag combination
        write_swap(1'b0);
        pending_quads.push_back(make_quad(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                          1'b1, 1'b1));
        pending_quads.push_back(make_quad(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                                          1'b1, 1'b1));
        pending_quads.push_back(make_quad(8'd128, 8'd128, 8'd16, 8'd235, 8'd15, 8'd236,
                                          1'b1, 1'b1));
        pending_quads.push_back(make_quad(8'd0, 8'd255, 8'd0, 8'd128, 8'd255, 8'd16,
                                          1'b1, 1'b1));
        pending_quads.push_back(make_quad(8'd255, 8'd0, 8'd0, 8'd128, 8'd255, 8'd235,
                                          1'b1, 1'b1));
        pending_quads.push_back(make_quad(8'd128, 8'd0, 8'd81, 8'd145, 8'd41, 8'd210,
                                          1'b1, 1'b1));
        pending_quads.push_back(make_quad(8'd0, 8'd128, 8'd81, 8'd145, 8'd41, 8'd210,
                                          1'b1, 1'b1));
        pending_quads.push_back(make_quad(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55,
                                          1'b1, 1'b1));
        pending_quads.push_back(make_quad(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA,
                                          1'b1, 1'b1));
        pending_quads.push_back(make_quad(8'd90, 8'd240, 8'd200, 8'd201, 8'd202, 8'd203,
                                          1'b0, 1'b1));
        pending_quads.push_back(make_quad(8'd90, 8'd240, 8'd200, 8'd201, 8'd202, 8'd203,
                                          1'b1, 1'b0));
        pending_quads.push_back(make_quad(8'd90, 8'd240, 8'd200, 8'd201, 8'd202, 8'd203,
                                          1'b0, 1'b0));
        pending_quads.push_back(make_quad(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                                          1'b0, 1'b0));
        pending_quads.push_back(make_quad(8'd16, 8'd240, 8'd1, 8'd254, 8'd127, 8'd128,
                                          1'b0, 1'b1));
        pending_quads.push_back(make_quad(8'd240, 8'd16, 8'd1, 8'd254, 8'd127, 8'd128,
                                          1'b1, 1'b0));
        pending_quads.push_back(make_quad(8'd128, 8'd128, 8'd0, 8'd255, 8'd16, 8'd235,
                                          1'b1, 1'b1));
        drain();

        random_phase(200, 1'b1);
        random_phase(200, 1'b0);
        random_phase(200, 1'b1);
        idle_on = 1'b0;
        random_phase(200, 1'b0);

        repeat (10) @(posedge i_clk);
        $display("Run covered %0d quads and %0d checked results over %0d swap settings,",
                 quads_sent, results_checked, swap_writes);
        $display("with edge flags, clamping extremes and a long receiver hold-off.");
        if (mismatches == 0 && rgb_expected.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
